// ===== sv/tun_pkg.sv =====
package tun_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int OUT_BITS       = 16;
	// magnitudes are scaled down to this many bits before the length is taken
	localparam int NORM_BITS      = 30;
	localparam int SQ_BITS        = 2 * NORM_BITS + 2;
	localparam int ROOT_BITS      = NORM_BITS + 1;
	localparam int QUEUE_DEPTH    = 4;

endpackage

// ===== sv/tun_if.sv =====
interface tun_in_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready
	);
endinterface

interface tun_out_if import tun_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] n_x;
	logic signed [OUT_BITS-1:0] n_y;
	logic signed [OUT_BITS-1:0] n_z;
	logic                       degenerate;

	modport source (
		output valid, n_x, n_y, n_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, n_x, n_y, n_z, degenerate,
		output ready
	);
endinterface

// ===== sv/tun_front.sv =====
module tun_front import tun_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NW         = 2 * COORD_BITS + 4
) (
	input  logic            clk,
	input  logic            arst_n,
	tun_in_if.sink          vtx,
	output logic            push_valid,
	input  logic            push_ready,
	output logic [3*NW-1:0] push_data
);

	localparam int C = COORD_BITS;

	logic signed [C-1:0]   crd [3][3];
	logic signed [C:0]     d_s1 [3][3];
	logic signed [C:0]     e_s1 [3][3];
	logic signed [2*C+1:0] prod_s2 [3][3];
	logic signed [NW-1:0]  n_s3 [3];
	logic                  vld_s1, vld_s2, vld_s3;
	logic                  en;

	always_comb begin
		crd[0][0] = vtx.a_x; crd[0][1] = vtx.a_y; crd[0][2] = vtx.a_z;
		crd[1][0] = vtx.b_x; crd[1][1] = vtx.b_y; crd[1][2] = vtx.b_z;
		crd[2][0] = vtx.c_x; crd[2][1] = vtx.c_y; crd[2][2] = vtx.c_z;
	end

	assign en         = !vld_s3 || push_ready;
	assign vtx.ready  = en;
	assign push_valid = vld_s3;
	assign push_data  = {n_s3[2], n_s3[1], n_s3[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vtx.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// axis i pairs the next two axes in cyclic order, edge j runs vertex j to j+1
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					d_s1[i][j] <= (C+1)'(crd[j][(i+1)%3]) - (C+1)'(crd[(j+1)%3][(i+1)%3]);
					e_s1[i][j] <= (C+1)'(crd[j][(i+2)%3]) + (C+1)'(crd[(j+1)%3][(i+2)%3]);
					prod_s2[i][j] <= d_s1[i][j] * e_s1[i][j];
				end
				n_s3[i] <= NW'(prod_s2[i][0]) + NW'(prod_s2[i][1]) + NW'(prod_s2[i][2]);
			end
		end
	end

endmodule

// ===== sv/tun_queue.sv =====
module tun_queue import tun_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != (AW+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

endmodule

// ===== sv/tun_back.sv =====
module tun_back import tun_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int NW         = 2 * COORD_BITS + 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  logic [3*NW-1:0] pop_data,
	tun_out_if.source       nrm
);

	localparam int BLW = $clog2(NW + 1);
	localparam int QW  = FRAC_BITS + 1;
	localparam int DW  = NORM_BITS + FRAC_BITS + 2;
	localparam int DVW = ROOT_BITS + 1;
	localparam int NST = 4 + 1 + ROOT_BITS + 1 + QW + 1;

	logic [NST-1:0] vld_q;
	logic           en;

	// scale and length
	logic [NW-1:0]        mag_s1 [3];
	logic [2:0]           sg_s1;
	logic                 zr_s1;
	logic [NW-1:0]        mag_s2 [3];
	logic [BLW-1:0]       sh_s2;
	logic [2:0]           sg_s2;
	logic                 zr_s2;
	logic [NORM_BITS-1:0] v_s3 [3];
	logic [2:0]           sg_s3;
	logic                 zr_s3;
	logic [2*NORM_BITS-1:0] sq_s4 [3];
	logic [NORM_BITS-1:0] v_s4 [3];
	logic [2:0]           sg_s4;
	logic                 zr_s4;

	// square root steps, index 0 holds the sum of squares
	logic [SQ_BITS-1:0]   rem_q [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] root_q [ROOT_BITS+1];
	logic [NORM_BITS-1:0] vv_q [ROOT_BITS+1][3];
	logic [2:0]           sgr_q [ROOT_BITS+1];
	logic                 zrr_q [ROOT_BITS+1];

	// division steps, index 0 holds numerators and divisor
	logic [DW-1:0]  drem_q [QW+1][3];
	logic [QW-1:0]  quo_q [QW+1][3];
	logic [DVW-1:0] dvs_q [QW+1];
	logic [2:0]     sgd_q [QW+1];
	logic           zrd_q [QW+1];

	logic signed [OUT_BITS-1:0] n_q [3];
	logic                       dg_q;

	logic [NW-1:0]  orv;
	logic [BLW-1:0] bl;

	assign en        = !vld_q[NST-1] || nrm.ready;
	assign pop_ready = en;
	assign nrm.valid = vld_q[NST-1];
	assign nrm.n_x   = n_q[0];
	assign nrm.n_y   = n_q[1];
	assign nrm.n_z   = n_q[2];
	assign nrm.degenerate = dg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NST-2:0], pop_valid};
	end

	// bit length of the largest magnitude equals that of their or
	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		bl  = '0;
		for (int b = 0; b < NW; b++) begin
			if (orv[b]) bl = BLW'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [NW-1:0] n;
				n = pop_data[i*NW +: NW];
				sg_s1[i]  <= n[NW-1];
				mag_s1[i] <= n[NW-1] ? (~n + 1'b1) : n;
			end
			zr_s1 <= pop_data == '0;

			mag_s2 <= mag_s1;
			sh_s2  <= (bl > BLW'(NORM_BITS)) ? bl - BLW'(NORM_BITS) : '0;
			sg_s2  <= sg_s1;
			zr_s2  <= zr_s1;

			for (int i = 0; i < 3; i++) v_s3[i] <= NORM_BITS'(mag_s2[i] >> sh_s2);
			sg_s3 <= sg_s2;
			zr_s3 <= zr_s2;

			for (int i = 0; i < 3; i++) sq_s4[i] <= v_s3[i] * v_s3[i];
			v_s4  <= v_s3;
			sg_s4 <= sg_s3;
			zr_s4 <= zr_s3;

			rem_q[0]  <= SQ_BITS'(sq_s4[0]) + SQ_BITS'(sq_s4[1]) + SQ_BITS'(sq_s4[2]);
			root_q[0] <= '0;
			vv_q[0]   <= v_s4;
			sgr_q[0]  <= sg_s4;
			zrr_q[0]  <= zr_s4;
		end
	end

	// one root bit per stage, most significant first
	for (genvar g = 1; g <= ROOT_BITS; g++) begin : g_sqrt
		localparam int K = ROOT_BITS - g;
		logic [SQ_BITS+1:0] t;
		logic               take;

		always_comb begin
			t    = (SQ_BITS+2)'({root_q[g-1], 2'b01}) << (2 * K);
			take = {2'b00, rem_q[g-1]} >= t;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g]  <= take ? rem_q[g-1] - t[SQ_BITS-1:0] : rem_q[g-1];
				root_q[g] <= {root_q[g-1][ROOT_BITS-2:0], take};
				vv_q[g]   <= vv_q[g-1];
				sgr_q[g]  <= sgr_q[g-1];
				zrr_q[g]  <= zrr_q[g-1];
			end
		end
	end

	// rounded quotient: (2 v 2^frac + len) / (2 len)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_q[0][i] <= (DW'(vv_q[ROOT_BITS][i]) << (FRAC_BITS + 1))
					+ DW'(root_q[ROOT_BITS]);
				quo_q[0][i]  <= '0;
			end
			dvs_q[0] <= {root_q[ROOT_BITS], 1'b0};
			sgd_q[0] <= sgr_q[ROOT_BITS];
			zrd_q[0] <= zrr_q[ROOT_BITS];
		end
	end

	for (genvar g = 1; g <= QW; g++) begin : g_div
		localparam int J = QW - g;
		logic [DW-1:0] t;
		logic [2:0]    take;

		always_comb begin
			t = DW'(dvs_q[g-1]) << J;
			for (int i = 0; i < 3; i++) take[i] = drem_q[g-1][i] >= t;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem_q[g][i] <= take[i] ? drem_q[g-1][i] - t : drem_q[g-1][i];
					quo_q[g][i]  <= {quo_q[g-1][i][QW-2:0], take[i]};
				end
				dvs_q[g] <= dvs_q[g-1];
				sgd_q[g] <= sgd_q[g-1];
				zrd_q[g] <= zrd_q[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [QW+OUT_BITS-1:0] qx;
				qx = (QW+OUT_BITS)'(quo_q[QW][i]);
				if (sgd_q[QW][i]) qx = ~qx + 1'b1;
				n_q[i] <= zrd_q[QW] ? '0 : qx[OUT_BITS-1:0];
			end
			dg_q <= zrd_q[QW];
		end
	end

endmodule

// ===== sv/triangle_unit_normal_core.sv =====
// triangle unit normal
// vtx carries one triangle per word: three counter-clockwise vertices a, b, c
// as signed fixed-point coordinates of COORD_BITS bits. nrm carries one
// result word per triangle: the unit normal n_x, n_y, n_z as signed
// Q1.FRAC_BITS values in 16 bits, and degenerate, set with a zero vector
// when the three vertices span no area.
// throughput is one triangle per cycle while nrm.ready does not stall the
// pipeline. an accepted triangle enters the first of 3 front stages forming
// the cross product, then passes the queue register, 7 back stages for
// magnitude, scaling, squares, sum, divide setup and output, one stage per
// square-root bit (31) and one per quotient bit (FRAC_BITS + 1).
// a four-word queue sits between front and back; when nrm.ready is low and a
// result waits, the back pipeline holds, the queue fills and vtx.ready drops
// once the queue is full and a word waits in the last front stage.
// reset clears all valid state; no results are pending after reset and the
// block takes a word in the first cycle after reset is released.
module triangle_unit_normal_core import tun_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tun_in_if.sink    vtx,
	tun_out_if.source nrm
);

	localparam int NW = 2 * COORD_BITS + 4;

	logic            f_valid, f_ready;
	logic [3*NW-1:0] f_data;
	logic            b_valid, b_ready;
	logic [3*NW-1:0] b_data;

	tun_front #(
		.COORD_BITS (COORD_BITS),
		.NW         (NW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	tun_queue #(
		.W (3 * NW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	tun_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.NW         (NW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data),
		.nrm       (nrm)
	);

endmodule

// ===== tb/triangle_unit_normal_core_test.sv =====
module triangle_unit_normal_core_test import tun_pkg::*; ();

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = 42 + FB;

	typedef struct {
		logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	} tri_t;

	typedef struct {
		logic signed [OUT_BITS-1:0] nx, ny, nz;
		logic degenerate;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tun_in_if #(.COORD_BITS(CB)) vtx ();
	tun_out_if nrm ();

	triangle_unit_normal_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.vtx(vtx),
		.nrm(nrm)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tri_t    tri_pending[$];
	normal_t normals_due[$];
	int      mismatches = 0;
	int      burst_left = 0;
	int      gap_left = 0;
	bit      hold_start = 1'b0;
	bit      hold_rx = 1'b0;
	bit      hold_sender = 1'b0;

	function automatic longint newell_sum(longint p0, longint q0, longint p1, longint q1,
			longint p2, longint q2);
		return (p0 - p1) * (q0 + q1) + (p1 - p2) * (q1 + q2) + (p2 - p0) * (q2 + q0);
	endfunction

	function automatic longint root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic normal_t unit_normal(tri_t t);
		longint n[3];
		longint unsigned mag[3];
		longint unsigned m, l2, len, q;
		int bl, sh;
		normal_t r;
		n[0] = newell_sum(t.ay, t.az, t.by, t.bz, t.cy, t.cz);
		n[1] = newell_sum(t.az, t.ax, t.bz, t.bx, t.cz, t.cx);
		n[2] = newell_sum(t.ax, t.ay, t.bx, t.by, t.cx, t.cy);
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = n[i] < 0 ? -n[i] : n[i];
			if (mag[i] > m)
				m = mag[i];
		end
		r = '{nx: 0, ny: 0, nz: 0, degenerate: 1'b1};
		if (m == 0)
			return r;
		bl = 0;
		while (bl < 64 && (m >> bl) != 0)
			bl++;
		sh = bl > NORM_BITS ? bl - NORM_BITS : 0;
		l2 = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] >>= sh;
			l2 += mag[i] * mag[i];
		end
		len = root_floor(l2);
		if (len == 0)
			len = 1;
		r.degenerate = 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << (FB + 1)) + len) / (2 * len);
			if (n[i] < 0)
				q = -q;
			case (i)
				0: r.nx = q[OUT_BITS-1:0];
				1: r.ny = q[OUT_BITS-1:0];
				default: r.nz = q[OUT_BITS-1:0];
			endcase
		end
		return r;
	endfunction

	function automatic logic [CB-1:0] rand_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($urandom_range(0, 15) - 8);
			2: return $urandom_range(0, 1) ? CB'(16'sh7fff - $urandom_range(0, 3))
				: CB'(16'sh8000 + $urandom_range(0, 3));
			default: return CB'($urandom_range(0, 511) - 256);
		endcase
	endfunction

	task automatic add_tri(int ax, ay, az, bx, by, bz, cx, cy, cz);
		tri_t t;
		t = '{CB'(ax), CB'(ay), CB'(az), CB'(bx), CB'(by), CB'(bz),
			CB'(cx), CB'(cy), CB'(cz)};
		tri_pending = {tri_pending, t};
	endtask

	task automatic add_random_tri();
		int mode;
		logic [CB-1:0] v[9];
		logic signed [CB-1:0] k;
		tri_t t;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 9; i++)
			v[i] = rand_coord(mode);
		// sometimes collinear: c = a + k(b - a) on small coordinates
		if ($urandom_range(0, 9) == 0) begin
			k = CB'($urandom_range(0, 4) - 2);
			for (int i = 0; i < 3; i++) begin
				v[i] = CB'($urandom_range(0, 255) - 128);
				v[3+i] = CB'($urandom_range(0, 255) - 128);
				v[6+i] = v[i] + k * (v[3+i] - v[i]);
			end
		end
		t = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		tri_pending = {tri_pending, t};
	endtask

	// sender: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			{vtx.a_x, vtx.a_y, vtx.a_z} <= '0;
			{vtx.b_x, vtx.b_y, vtx.b_z} <= '0;
			{vtx.c_x, vtx.c_y, vtx.c_z} <= '0;
		end else begin
			automatic bit taken = vtx.valid && vtx.ready;
			automatic bit busy = vtx.valid && !vtx.ready;
			if (taken)
				normals_due = {normals_due, unit_normal(tri_pending.pop_front())};
			if (!busy) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0 && burst_left == 0 || hold_sender || tri_pending.size() == 0) begin
					if (gap_left > 0 && burst_left == 0)
						gap_left--;
					vtx.valid <= 1'b0;
				end else begin
					if (burst_left > 0)
						burst_left--;
					vtx.valid <= 1'b1;
					vtx.a_x <= tri_pending[0].ax; vtx.a_y <= tri_pending[0].ay;
					vtx.a_z <= tri_pending[0].az; vtx.b_x <= tri_pending[0].bx;
					vtx.b_y <= tri_pending[0].by; vtx.b_z <= tri_pending[0].bz;
					vtx.c_x <= tri_pending[0].cx; vtx.c_y <= tri_pending[0].cy;
					vtx.c_z <= tri_pending[0].cz;
				end
			end
		end
	end

	// receiver: own stall pattern, plus a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm.ready <= 1'b0;
		end else begin
			automatic normal_t exp_n;
			if (nrm.valid && nrm.ready) begin
				if (normals_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word n=(%0d,%0d,%0d) deg=%b",
							nrm.n_x, nrm.n_y, nrm.n_z, nrm.degenerate);
				end else begin
					exp_n = normals_due.pop_front();
					if (exp_n.nx !== nrm.n_x || exp_n.ny !== nrm.n_y ||
							exp_n.nz !== nrm.n_z || exp_n.degenerate !== nrm.degenerate) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp=(%0d,%0d,%0d,%b) got=(%0d,%0d,%0d,%b)",
								exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degenerate,
								nrm.n_x, nrm.n_y, nrm.n_z, nrm.degenerate);
					end
				end
			end
			if (hold_rx)
				nrm.ready <= 1'b0;
			else
				nrm.ready <= ($time / 80) % 5 == 0 ? $urandom_range(0, 3) != 0 : 1'b1;
		end
	end

	// long receiver hold-off, counted in cycles here
	initial begin
		wait (hold_start);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		// directed
		add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
		add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
		add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
		add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5);
		add_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
		add_tri(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768);
		add_tri(32767, 32767, 32767, -32768, 32767, -32768,
			-32768, -32768, 32767);
		add_tri(-32768, 32767, -32768, 32767, -32768, 32767,
			-32768, -32768, -32768);
		add_tri(-1, -1, -1, 32767, -32768, 1,
			-32767, 0, 32766);
		add_tri(0, 0, 0, 3, 0, 0, 0, 4, 0);
		add_tri(1, 2, 3, 3, 2, 1, 2, 3, 1);
		add_tri(-1, -1, -1, -1, -1, -1, -2, -2, -2);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) add_random_tri();
		// long receiver hold-off while the sender keeps offering
		wait (tri_pending.size() < 280);
		@(posedge clk);
		hold_start = 1'b1;
		repeat (300) add_random_tri();
		wait (tri_pending.size() == 0);
		// sender pauses until every expected word has come back
		hold_sender = 1'b1;
		wait (normals_due.size() == 0 && !vtx.valid);
		@(posedge clk);
		hold_sender = 1'b0;
		repeat (400) add_random_tri();
		wait (tri_pending.size() == 0 && !vtx.valid);
		wait (normals_due.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && normals_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
